[design/bmpw_pkg.sv]
// shared types, codes and constants of the bicolor matrix pixel writer
package bmpw_pkg;

    // input operation codes
    localparam logic [1:0] OP_PLOT      = 2'd0;
    localparam logic [1:0] OP_READ_LIVE = 2'd1;
    localparam logic [1:0] OP_READ_SNAP = 2'd2;
    localparam logic [1:0] OP_SNAPSHOT  = 2'd3;

    // classified command kinds carried through the queue
    localparam logic [1:0] CMD_PLOT     = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_SNAPSHOT = 2'd2;

    // result kinds
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    // serial frame id sent ahead of the address
    localparam logic [2:0] FRAME_ID = 3'b101;

    // matrix geometry
    localparam int COL_LIMIT = 32;
    localparam int ROW_LIMIT = 16;

    // one store row holds the green word (low byte) and red word (high byte)
    localparam int ROW_AW = 7;
    localparam int ROWS   = 1 << ROW_AW;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]        cmd_kind;
        logic              snap_sel;
        logic              on_matrix;
        logic [ROW_AW-1:0] row_index;
        logic [3:0]        bit_mask;
        logic [1:0]        color;
        logic [2:0]        chip;
        logic [4:0]        addr;
    } cmd_t;

endpackage

[design/bmpw_if.sv]
// handshake channels: pixel commands in, driver frames and read answers out
interface bmpw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] column;
    logic [4:0] row;
    logic [2:0] pixel_color;

    modport source (output valid, operation, column, row, pixel_color, input ready);
    modport sink (input valid, operation, column, row, pixel_color, output ready);
endinterface

interface bmpw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  chip;
    logic [5:0]  word_address;
    logic [3:0]  nibble;
    logic [13:0] frame_bits;
    logic [1:0]  read_color;
    logic        last;

    modport source (output valid, kind, chip, word_address, nibble, frame_bits,
                    read_color, last, input ready);
    modport sink (input valid, kind, chip, word_address, nibble, frame_bits,
                  read_color, last, output ready);
endinterface

[design/bicolor_matrix_pixel_writer.sv]
// top level of the bicolor matrix pixel writer: front end, queue, store sequencer
//
// usage:
//   cmd carries one beat per command (operation, column, row, pixel_color);
//   res carries driver write frames (kind 0) and pixel read answers (kind 1),
//   with last set on the final beat a command produces.
//   a changing plot gives two beats, green frame then red frame; reads give
//   one answer; a snapshot, a plot that changes nothing, an off-matrix plot
//   and a plot with an unknown color give no beat.
// flow:
//   the front end decodes in the cycle a beat is taken and the queue holds
//   up to QueueDepth commands, so cmd stays ready while the sequencer works
//   until the queue is full. a beat passes the queue, the store read and
//   the output register; the red frame follows the green frame.
//   the sequencer handles one command at a time, bounded by the single
//   store read port: a read or plot reads its row first; a snapshot reads
//   and rewrites each of the 128 rows in turn.
// reset:
//   asynchronous and active low; queue and output register empty, every
//   store row marked unwritten so it reads as all zeros. no clearing pass.
// stall:
//   while res is not ready the output beat holds and the sequencer waits;
//   the queue then fills and cmd ready drops once it is full.
module bicolor_matrix_pixel_writer #(
    parameter int QueueDepth = bmpw_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    bmpw_in_if.sink    cmd,
    bmpw_out_if.source res
);
    import bmpw_pkg::*;

    // front end to queue
    logic push;
    cmd_t push_entry;
    logic queue_full;

    // queue to sequencer
    logic head_valid;
    cmd_t head_entry;
    logic pop;

    // decode and filter incoming command beats
    bmpw_front u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    // decouples intake from the store sequencer
    bmpw_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // shadow store, frame building and read answers
    bmpw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .res        (res)
    );

endmodule

[design/bmpw_front.sv]
// front end: takes command beats, decodes coordinates and drops dead plots
module bmpw_front (
    bmpw_in_if.sink        cmd,
    input  logic           queue_full,
    output logic           push,
    output bmpw_pkg::cmd_t entry
);
    import bmpw_pkg::*;

    logic       on_matrix;
    logic [1:0] quarter;
    logic       keep;

    assign on_matrix = (cmd.column < 6'(COL_LIMIT)) && (cmd.row < 5'(ROW_LIMIT));
    assign quarter   = {cmd.row[3], cmd.column[4]};

    always_comb
    begin
        entry           = '0;
        entry.on_matrix = on_matrix;
        entry.addr      = {cmd.column[3:0], cmd.row[2]};
        entry.row_index = {quarter, cmd.column[3:0], cmd.row[2]};
        entry.bit_mask  = 4'b1000 >> cmd.row[1:0];
        entry.color     = cmd.pixel_color[1:0];
        entry.chip      = {1'b0, quarter} + 3'd1;
        entry.snap_sel  = (cmd.operation == OP_READ_SNAP);
        keep            = 1'b1;
        case (cmd.operation)
            OP_PLOT:
            begin
                entry.cmd_kind = CMD_PLOT;
                // off-matrix plots and unknown colors never reach the store
                keep = on_matrix && !cmd.pixel_color[2];
            end
            OP_READ_LIVE, OP_READ_SNAP:
            begin
                entry.cmd_kind = CMD_READ;
            end
            OP_SNAPSHOT:
            begin
                entry.cmd_kind = CMD_SNAPSHOT;
            end
            default:
            begin
                entry.cmd_kind = CMD_READ;
            end
        endcase
    end

    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full && keep;

endmodule

[design/bmpw_queue.sv]
// small command queue between the front end and the store sequencer
module bmpw_queue #(
    parameter int QueueDepth = bmpw_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bmpw_pkg::cmd_t push_entry,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output bmpw_pkg::cmd_t head_entry
);
    import bmpw_pkg::*;

    localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CW = $clog2(QueueDepth + 1);

    cmd_t          q_mem [QueueDepth];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_entry = q_mem[rd_ptr_reg];

    always_comb
    begin
        // pointers wrap at the depth, which need not be a power of two
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QueueDepth))
        else $error("queue count beyond depth");

endmodule

[design/bmpw_back.sv]
// back end: shadow store, plot/read/snapshot sequencer and output register
module bmpw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  bmpw_pkg::cmd_t head_entry,
    output logic           pop,
    bmpw_out_if.source     res
);
    import bmpw_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ANSWER = 3'd1;
    localparam logic [2:0] S_PLOT   = 3'd2;
    localparam logic [2:0] S_RED    = 3'd3;
    localparam logic [2:0] S_SW_RD  = 3'd4;
    localparam logic [2:0] S_SW_WR  = 3'd5;

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ROW_AW-1:0] sweep_reg, sweep_next;
    logic [3:0]        red_nib_reg, red_nib_next;

    // store: {red word, green word} per row, unwritten rows read as zero
    logic [15:0]       mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [15:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              we;
    logic [ROW_AW-1:0] wr_addr;
    logic [15:0]       wr_data;

    logic [7:0] g_word, r_word;
    logic [3:0] g_live_new, r_live_new;
    logic [3:0] g_sel, r_sel;
    logic [1:0] cur_color, ans_color;
    logic [3:0] mask;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [2:0]  out_chip_reg, out_chip_next;
    logic [5:0]  out_addr_reg, out_addr_next;
    logic [3:0]  out_nib_reg, out_nib_next;
    logic [13:0] out_bits_reg, out_bits_next;
    logic [1:0]  out_color_reg, out_color_next;
    logic        out_last_reg, out_last_next;
    logic        out_free;
    logic        out_load;

    assign out_free = !out_valid_reg || res.ready;

    assign g_word = rd_valid_reg ? rd_data_reg[7:0] : 8'd0;
    assign r_word = rd_valid_reg ? rd_data_reg[15:8] : 8'd0;
    assign mask   = cmd_reg.bit_mask;

    assign cur_color  = {|(r_word[3:0] & mask), |(g_word[3:0] & mask)};
    assign g_live_new = cmd_reg.color[0] ? (g_word[3:0] | mask) : (g_word[3:0] & ~mask);
    assign r_live_new = cmd_reg.color[1] ? (r_word[3:0] | mask) : (r_word[3:0] & ~mask);
    assign g_sel      = cmd_reg.snap_sel ? g_word[7:4] : g_word[3:0];
    assign r_sel      = cmd_reg.snap_sel ? r_word[7:4] : r_word[3:0];
    assign ans_color  = cmd_reg.on_matrix ? {|(r_sel & mask), |(g_sel & mask)} : 2'd0;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sweep_next     = sweep_reg;
        red_nib_next   = red_nib_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cmd_reg.row_index;
        we             = 1'b0;
        wr_addr        = cmd_reg.row_index;
        wr_data        = {r_word[7:4], r_live_new, g_word[7:4], g_live_new};
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_chip_next  = out_chip_reg;
        out_addr_next  = out_addr_reg;
        out_nib_next   = out_nib_reg;
        out_bits_next  = out_bits_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head_entry;
                    rd_addr  = head_entry.row_index;
                    case (head_entry.cmd_kind)
                        CMD_READ:
                        begin
                            rd_en      = head_entry.on_matrix;
                            state_next = S_ANSWER;
                        end
                        CMD_PLOT:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_PLOT;
                        end
                        CMD_SNAPSHOT:
                        begin
                            sweep_next = '0;
                            state_next = S_SW_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ANSWER:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = KIND_ANSWER;
                    out_chip_next  = 3'd0;
                    out_addr_next  = 6'd0;
                    out_nib_next   = 4'd0;
                    out_bits_next  = 14'd0;
                    out_color_next = ans_color;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PLOT:
            begin
                if (cur_color == cmd_reg.color)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    we             = 1'b1;
                    red_nib_next   = r_live_new;
                    out_load       = 1'b1;
                    out_kind_next  = KIND_FRAME;
                    out_chip_next  = cmd_reg.chip;
                    out_addr_next  = {1'b0, cmd_reg.addr};
                    out_nib_next   = g_live_new;
                    out_bits_next  = {FRAME_ID, 2'b00, cmd_reg.addr, g_live_new};
                    out_color_next = 2'd0;
                    out_last_next  = 1'b0;
                    state_next     = S_RED;
                end
            end
            S_RED:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = KIND_FRAME;
                    out_chip_next  = cmd_reg.chip;
                    out_addr_next  = {1'b1, cmd_reg.addr};
                    out_nib_next   = red_nib_reg;
                    out_bits_next  = {FRAME_ID, 2'b01, cmd_reg.addr, red_nib_reg};
                    out_color_next = 2'd0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SW_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = sweep_reg;
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                we         = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = {r_word[3:0], r_word[3:0], g_word[3:0], g_word[3:0]};
                sweep_next = sweep_reg + ROW_AW'(1);
                state_next = (&sweep_reg) ? S_IDLE : S_SW_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (we)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        sweep_reg      <= sweep_next;
        red_nib_reg    <= red_nib_next;
        out_kind_reg   <= out_kind_next;
        out_chip_reg   <= out_chip_next;
        out_addr_reg   <= out_addr_next;
        out_nib_reg    <= out_nib_next;
        out_bits_reg   <= out_bits_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_kind_reg;
    assign res.chip         = out_chip_reg;
    assign res.word_address = out_addr_reg;
    assign res.nibble       = out_nib_reg;
    assign res.frame_bits   = out_bits_reg;
    assign res.read_color   = out_color_reg;
    assign res.last         = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || res.ready))
        else $error("output beat overwritten before it was taken");
    a_green_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED) |-> (out_valid_reg && !out_last_reg
                                  && out_kind_reg == KIND_FRAME))
        else $error("red frame state without a pending green frame");
    a_frame_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_FRAME) |->
        (out_bits_reg[13:11] == FRAME_ID && out_bits_reg[3:0] == out_nib_reg
         && out_bits_reg[9:4] == out_addr_reg && out_chip_reg != 3'd0))
        else $error("malformed driver write frame");
    a_answer_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_ANSWER) |-> out_last_reg)
        else $error("read answer not marked last");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("command taken while sequencer busy");

endmodule
